@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge once reset is released
`define ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

@@ sv/mhpq_pkg.sv @@
// Shared constants and types of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // request kinds
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // result status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ sv/max_heap_priority_queue.sv @@
// Binary max-heap priority queue: top level and sift sequencer
//
// Holds up to CAPACITY (1024) signed 32-bit keys in one RAM arranged as a
// binary max-heap. Each input word carries a command in tuser (0 insert,
// 1 extract max, 2 peek max, 3 no operation) and a key in tdata; each request
// returns exactly one output word: the key in tdata (zero unless an extract or
// peek succeeded) and a status in tuser (0 ok, 1 empty, 2 full). The block
// works on one request at a time; the heap RAM has one read and one write
// port with a registered read, and every level of a sift costs RAM reads.
// An insert climbs the heap one level per parent read and compare; an
// extract reads the root and then the last key, and descends one level per
// read of both children and a compare; a peek reads the root. The block
// returns to idle and takes the next request once the result is loaded
// into the output register; while that register is still occupied it waits
// in its final state. The output register holds a result until it is taken
// while the next request is already being worked on.
`timescale 1ns / 1ps

module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] key
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LOAD,
        S_DN_RD_L,
        S_DN_RD_R,
        S_DN_CMP,
        S_PK_LOAD,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [ADDR_W-1:0]        r_pos,   n_pos;
    logic signed [KEY_W-1:0]  r_key,   n_key;
    logic signed [KEY_W-1:0]  r_lval,  n_lval;
    logic [KEY_W-1:0]         r_val,   n_val;
    t_status                  r_st,    n_st;
    logic                     r_m_valid, n_m_valid;
    logic [KEY_W-1:0]         r_m_data,  n_m_data;
    t_status                  r_m_user,  n_m_user;

    // RAM port
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [KEY_W-1:0]         w_wdata;
    logic [ADDR_W-1:0]        w_raddr;
    logic [KEY_W-1:0]         w_rdata;

    // heap index arithmetic
    logic [ADDR_W-1:0]        w_up;
    logic [ADDR_W+1:0]        w_left;
    logic [ADDR_W+1:0]        w_right;
    logic                     w_left_ok;
    logic                     w_right_ok;
    logic                     w_take_r;
    logic signed [KEY_W-1:0]  w_child;
    logic [ADDR_W-1:0]        w_child_idx;
    t_cmd                     w_cmd;
    logic                     w_accept;

    assign w_cmd      = t_cmd'(i_s_tuser);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_up       = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
    assign w_left     = {1'b0, r_pos, 1'b1};
    assign w_right    = {1'b0, r_pos, 1'b0} + (ADDR_W+2)'(2);
    assign w_left_ok  = w_left  < (ADDR_W+2)'(r_count);
    assign w_right_ok = w_right < (ADDR_W+2)'(r_count);

    // larger child, left wins a tie
    assign w_take_r    = w_right_ok && ($signed(w_rdata) > r_lval);
    assign w_child     = w_take_r ? $signed(w_rdata) : r_lval;
    assign w_child_idx = w_take_r ? w_right[ADDR_W-1:0] : w_left[ADDR_W-1:0];

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // read address follows the state; the root is read ahead while idle
    always_comb begin
        case (r_state)
            S_IDLE:    w_raddr = '0;
            S_EX_ROOT: w_raddr = r_count[ADDR_W-1:0];
            S_UP_RD:   w_raddr = w_up;
            S_DN_RD_L: w_raddr = w_left[ADDR_W-1:0];
            S_DN_RD_R: w_raddr = w_right[ADDR_W-1:0];
            default:   w_raddr = '0;
        endcase
    end

    // sequencer next state, heap writes and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_lval    = r_lval;
        n_val     = r_val;
        n_st      = r_st;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_key;

        // output word taken
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_val = '0;
                    n_st  = ST_OK;
                    case (w_cmd)
                        CMD_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_st    = ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_pos   = r_count[ADDR_W-1:0];
                                n_key   = $signed(i_s_tdata);
                                n_count = r_count + CNT_W'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_st    = ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                n_state = S_EX_ROOT;
                            end
                        end
                        CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_st    = ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_PK_LOAD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // sift up: compare the hole's parent with the new key
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_key > $signed(w_rdata)) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_pos   = w_up;
                    n_state = S_UP_RD;
                end else begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end
            end

            // extract: root arrives, then the last key becomes the sifted key
            S_EX_ROOT: begin
                n_val = w_rdata;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EX_LOAD;
                end
            end
            S_EX_LOAD: begin
                n_key   = $signed(w_rdata);
                n_pos   = '0;
                n_state = S_DN_RD_L;
            end

            // sift down: read both children, move the larger one up
            S_DN_RD_L: begin
                if (!w_left_ok) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD_R;
                end
            end
            S_DN_RD_R: begin
                n_lval  = $signed(w_rdata);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (w_child > r_key) begin
                    w_we    = 1'b1;
                    w_wdata = w_child;
                    n_pos   = w_child_idx;
                    n_state = S_DN_RD_L;
                end else begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_PK_LOAD: begin
                n_val   = w_rdata;
                n_state = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_val;
                    n_m_user  = r_st;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_lval   <= n_lval;
        r_val    <= n_val;
        r_st     <= n_st;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

@@ sv/mhpq_ram.sv @@
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mhpq_checker.sv @@
// Port-level checks of the max-heap priority queue, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhpq_checker
    import mhpq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // no result word is left after a reset cycle
    `ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_m_tvalid)

    // status is one of the defined codes
    `ASSERT_RST(a_status_code, o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_EMPTY
        || o_m_tuser == ST_FULL))

    // a failed (empty or full) request reports a zero key
    `ASSERT_RST(a_err_zero, (o_m_tvalid && (o_m_tuser == ST_EMPTY || o_m_tuser == ST_FULL))
        |-> (o_m_tdata == '0))

    // a stalled result word stays valid and keeps its key
    `ASSERT_RST(a_out_hold, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

@@ verif/tb_max_heap_priority_queue.sv @@
// Self-checking testbench for the max-heap priority queue
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;
    import mhpq_pkg::*;

    // one expected output word
    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_heap_result;

    // one row of the directed stimulus; known rows carry their result typed in
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
        bit          known;
        logic [31:0] value;
        t_status     status;
    } t_stim_row;

    localparam int ROWS = 24;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [31:0] key
    logic [1:0]  i_s_tuser  = '0;   // [1:0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [31:0] value
    logic [1:0]  o_m_tuser;         // [1:0] status

    // shadow heap and pending results
    logic signed [31:0] heap_keys [CAPACITY];
    int                 heap_count = 0;
    t_heap_result       pending_results [$];
    int                 mismatch_count = 0;

    // sender pacing and receiver hold-off request
    int burst_left = 0;
    bit no_idle    = 1'b0;
    bit hold_req   = 1'b0;

    // directed rows: empty heap, extremes, ties, no-op, drain back to empty
    t_stim_row stim_table [0:ROWS-1] = '{
        '{CMD_EXTRACT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_PEEK,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_NOP,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_INSERT,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_PEEK,    32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
        '{CMD_INSERT,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_PEEK,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{CMD_INSERT,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_INSERT,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_INSERT,  32'h0000_0005, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_INSERT,  32'h0000_0005, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_INSERT,  32'h0000_0005, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'h5555_5555, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_PEEK,    32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{CMD_EXTRACT, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_NOP,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_INSERT,  32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_OK},
        '{CMD_NOP,     32'h5555_5555, 1'b1, 32'h0000_0000, ST_OK}
    };

    max_heap_priority_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #1_000_000;
        $display("tb_max_heap_priority_queue: FAIL");
        $finish;
    end

    // apply one request to the shadow heap and return its result
    function automatic t_heap_result apply_request(input t_cmd cmd, input logic [31:0] key);
        t_heap_result       res;
        int                 pos;
        int                 up;
        int                 l;
        int                 r;
        int                 best;
        logic signed [31:0] tmp;
        res.value  = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (heap_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // sift up from the first free slot, strict compare
                    pos = heap_count;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!($signed(key) > heap_keys[up])) break;
                        heap_keys[pos] = heap_keys[up];
                        pos = up;
                    end
                    heap_keys[pos] = key;
                    heap_count++;
                end
            end
            CMD_EXTRACT: begin
                if (heap_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = heap_keys[0];
                    heap_count--;
                    heap_keys[0] = heap_keys[heap_count];
                    // sift down; left child wins a tie
                    pos = 0;
                    while (1) begin
                        l = 2 * pos + 1;
                        r = 2 * pos + 2;
                        best = pos;
                        if (l < heap_count && heap_keys[l] > heap_keys[best]) best = l;
                        if (r < heap_count && heap_keys[r] > heap_keys[best]) best = r;
                        if (best == pos) break;
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[best];
                        heap_keys[best] = tmp;
                        pos = best;
                    end
                end
            end
            CMD_PEEK: begin
                if (heap_count == 0) res.status = ST_EMPTY;
                else res.value = heap_keys[0];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_cmd pick_cmd(input int w_ins, input int w_ext, input int w_peek);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins) return CMD_INSERT;
        if (r < w_ins + w_ext) return CMD_EXTRACT;
        if (r < w_ins + w_ext + w_peek) return CMD_PEEK;
        return CMD_NOP;
    endfunction

    // full-range keys, small clustered keys and multiples of 1000 for ties, and extremes
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return 32'($signed($urandom_range(0, 15)) - 8);
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:       return 32'd1000 * $urandom_range(0, 3);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // offer one word in the current burst, wait for acceptance, predict its result
    task automatic send_request(input t_cmd cmd, input logic [31:0] key, input bit known,
                                input t_heap_result typed);
        int           gap;
        t_heap_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = apply_request(cmd, key);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic send_random(input int w_ins, input int w_ext, input int w_peek);
        send_request(pick_cmd(w_ins, w_ext, w_peek), pick_key(), 1'b0, '0);
    endtask

    // stop offering words and wait for every expected result
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: segments of steady, random, alternating and sparse ready, plus one long hold-off
    initial begin
        int seg_left;
        int mode;
        int hold_cycles;
        seg_left = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_cycles = 0;
                i_m_tready <= 1'b0;
                while (hold_cycles < 300) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 120);
                mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 9) < 7);
                2:       i_m_tready <= seg_left[0];
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word value=%h status=%0d",
                                          o_m_tdata, o_m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.value)
                    report_mismatch($sformatf("value %h, expected %h", o_m_tdata, want.value));
                if (o_m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_m_tuser,
                                              want.status));
            end
        end
    end

    // main sequence
    initial begin
        t_heap_result typed;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int i = 0; i < ROWS; i++) begin
            typed.value  = stim_table[i].value;
            typed.status = stim_table[i].status;
            send_request(stim_table[i].cmd, stim_table[i].key, stim_table[i].known, typed);
        end
        wait_drained();

        // mixed traffic; long output stall partway through
        for (int i = 0; i < 100; i++) begin
            if (i == 30) hold_req = 1'b1;
            send_random(45, 30, 20);
        end
        wait_drained();

        // fill to capacity, then push inserts into a full heap
        no_idle = 1'b1;
        for (int i = 0; heap_count < CAPACITY; i++) begin
            if (i == 300) no_idle = 1'b0;
            send_random(100, 0, 0);
        end
        no_idle = 1'b0;
        for (int i = 0; i < 30; i++) send_random(80, 0, 17);
        wait_drained();

        // extract-heavy traffic on the full heap, deepest sifts
        for (int i = 0; i < 80; i++) send_random(10, 80, 8);
        wait_drained();

        // closing mixed traffic
        for (int i = 0; i < 40; i++) send_random(40, 35, 20);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_max_heap_priority_queue: PASS");
        end else begin
            $display("tb_max_heap_priority_queue: FAIL");
        end
        $finish;
    end

endmodule
